// File: rtl/itu_f699_antenna_gain_defines.svh
// Assertion macros shared by the checker.
`ifndef ITU_F699_ANTENNA_GAIN_DEFINES_SVH
`define ITU_F699_ANTENNA_GAIN_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define F699_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define F699_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/f699_pkg.sv
`timescale 1ns / 1ps
package f699_pkg;

	localparam int FRAC_BITS      = 8;
	localparam int LOG_TABLE_BITS = 10;
	localparam int QW             = 16;

	localparam int ANGLE_W = 18;
	localparam int ANG_W   = 16;
	localparam int MAXG_W  = 15;
	localparam int AR_W    = 24;
	localparam int GAIN_W  = 16;
	localparam int CFG_W   = 24;

	localparam int LOG_STAGES = LOG_TABLE_BITS + 1;
	localparam int SEL_STAGES = 5;
	localparam int NUM_STAGES = 1 + LOG_STAGES + SEL_STAGES;

	localparam int MANT_W = 31;
	localparam int P_W    = 5;
	localparam int L2_W   = 21;
	localparam int GW     = 26;
	localparam int LOSS_W = 24;

	typedef enum logic {
		REG_MAX_GAIN = 1'b0,
		REG_APERTURE = 1'b1
	} reg_idx_t;

	localparam logic [MAXG_W-1:0] MAX_GAIN_RST = MAXG_W'(10240);
	localparam logic [AR_W-1:0]   APERTURE_RST = AR_W'(25600);

	localparam int ANG_PER  = 360 << FRAC_BITS;
	localparam int ANG_HALF = 180 << FRAC_BITS;

	localparam logic [AR_W-1:0]  AR_LARGE = AR_W'(100 << FRAC_BITS);
	localparam logic [ANG_W-1:0] ANG_48   = ANG_W'(48 << FRAC_BITS);
	localparam logic [39:0]      NEAR_LIM = 40'(100) << (2 * FRAC_BITS);
	localparam logic [32:0]      DP_LIM   = 33'(8192) << FRAC_BITS;

	// floor(x/25) = (x * M25) >> 33 for x < 2^28
	localparam logic [28:0] M25    = 29'd343597384;
	localparam int          M25_SH = 33;
	// floor(x/5) = (x * M5) >> 25 for x < 2^22
	localparam logic [22:0] M5     = 23'd6710887;
	localparam int          M5_SH  = 25;

	localparam logic [28:0] LOG10_2_Q30   = 29'd323228497;
	localparam int          LOG2_1585_Q16 = 261253;

	localparam int GAIN_MIN = -8192;
	localparam int GAIN_MAX = 32767;

	typedef struct packed {
		logic [MAXG_W-1:0] gmax;
		logic              hi_ar;
		logic              zero;
		logic              lt48;
		logic              near;
		logic              big;
		logic [LOSS_W-1:0] loss;
	} side_t;

	// Round half away from zero, drop 30 fraction bits.
	function automatic logic signed [L2_W-1:0] rnd30(input logic signed [50:0] v);
		logic [50:0] mag;
		logic [20:0] r;
		mag = v[50] ? 51'(-v) : 51'(v);
		r   = 21'((mag + (51'(1) << 29)) >> 30);
		return v[50] ? $signed(-L2_W'(r)) : $signed(L2_W'(r));
	endfunction

endpackage

// File: rtl/f699_front.sv
`timescale 1ns / 1ps
module f699_front (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [f699_pkg::ANGLE_W-1:0]   off_axis_angle,
	input  logic        [f699_pkg::AR_W-1:0]      ar,
	input  logic        [f699_pkg::MAXG_W-1:0]    gmax,
	output logic        [f699_pkg::ANG_W-1:0]     ang_s1,
	output logic        [f699_pkg::AR_W-1:0]      ar_s1,
	output logic        [f699_pkg::MAXG_W-1:0]    gmax_s1
);
	import f699_pkg::*;

	logic signed [19:0] v;
	logic signed [19:0] r;
	logic signed [19:0] f;

	// modulo one turn, then mirror into 0..180
	always_comb begin
		v = 20'(off_axis_angle);
		if (v < -20'sd92160)
			r = v + 20'(2 * ANG_PER);
		else if (v < 0)
			r = v + 20'(ANG_PER);
		else if (v >= 20'(ANG_PER))
			r = v - 20'(ANG_PER);
		else
			r = v;
		f = (r > 20'(ANG_HALF)) ? 20'(ANG_PER) - r : r;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1  <= ANG_W'(f);
			ar_s1   <= (ar == '0) ? AR_W'(1) : ar;
			gmax_s1 <= gmax;
		end
	end

endmodule

// File: rtl/f699_log2.sv
`timescale 1ns / 1ps
module f699_log2 #(
	parameter int XW = f699_pkg::AR_W
) (
	input  logic                                   clk,
	input  logic [f699_pkg::LOG_STAGES-1:0]        en,
	input  logic [XW-1:0]                          x,
	output logic signed [f699_pkg::L2_W-1:0]       l2
);
	import f699_pkg::*;

	localparam int LAST = LOG_STAGES - 1;

	logic [XW-1:0]             xx;
	logic [P_W-1:0]            p_c;
	logic [MANT_W-1:0]         m_c;
	logic [P_W-1:0]            p_s  [LOG_STAGES];
	logic [MANT_W-1:0]         m_s  [LOG_STAGES];
	logic [LOG_TABLE_BITS-1:0] fr_s [LOG_STAGES];

	// normalise: mantissa in [2^30, 2^31)
	always_comb begin
		xx  = (x == '0) ? XW'(1) : x;
		p_c = '0;
		for (int i = 0; i < XW; i++)
			if (xx[i]) p_c = P_W'(i);
		m_c = MANT_W'(xx) << (P_W'(MANT_W - 1) - p_c);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_s[0]  <= p_c;
			m_s[0]  <= m_c;
			fr_s[0] <= '0;
		end
	end

	// one squaring per stage, one fraction bit out
	for (genvar k = 1; k < LOG_STAGES; k++) begin : g_sq
		logic [2*MANT_W-1:0] sq;
		logic [31:0]         t;
		logic [MANT_W-1:0]   m_n;

		always_comb begin
			sq  = m_s[k-1] * m_s[k-1];
			t   = sq[61:30];
			m_n = t[31] ? t[31:1] : t[30:0];
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				p_s[k]  <= p_s[k-1];
				m_s[k]  <= m_n;
				fr_s[k] <= {fr_s[k-1][LOG_TABLE_BITS-2:0], t[31]};
			end
		end
	end

	assign l2 = $signed((L2_W'(p_s[LAST]) << QW)
		+ (L2_W'(fr_s[LAST]) << (QW - LOG_TABLE_BITS))
		- L2_W'(FRAC_BITS << QW));

endmodule

// File: rtl/f699_loss.sv
`timescale 1ns / 1ps
module f699_loss (
	input  logic                                clk,
	input  logic [f699_pkg::LOG_STAGES-1:0]     en,
	input  logic [f699_pkg::ANG_W-1:0]          ang,
	input  logic [f699_pkg::AR_W-1:0]           ar,
	input  logic [f699_pkg::MAXG_W-1:0]         gmax,
	output f699_pkg::side_t                     side
);
	import f699_pkg::*;

	side_t       side_s [LOG_STAGES];
	logic [39:0] prod_s;
	logic [21:0] dp_s;
	logic [43:0] sq_s;
	logic [27:0] x_s;
	logic [56:0] qm_s;

	logic [40:0] dp_full;
	logic [44:0] n_c;
	side_t       sd0;
	side_t       sd1;
	side_t       sd3;
	side_t       sd5;

	always_comb begin
		sd0       = '0;
		sd0.gmax  = gmax;
		sd0.hi_ar = ar > AR_LARGE;
		sd0.zero  = ang == '0;
		sd0.lt48  = ang < ANG_48;

		dp_full  = (41'(prod_s) + 41'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		sd1      = side_s[0];
		sd1.near = prod_s < NEAR_LIM;
		sd1.big  = dp_full > 41'(DP_LIM);

		n_c     = 45'(sq_s) + 45'd200;
		sd3     = side_s[2];
		sd3.big = side_s[2].big || (n_c[44:32] != '0);

		sd5      = side_s[4];
		sd5.loss = qm_s[56:M25_SH];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s    <= 40'(ar) * 40'(ang);
			side_s[0] <= sd0;
		end
		if (en[1]) begin
			dp_s      <= dp_full[21:0];
			side_s[1] <= sd1;
		end
		if (en[2]) begin
			sq_s      <= dp_s * dp_s;
			side_s[2] <= side_s[1];
		end
		if (en[3]) begin
			x_s       <= n_c[31:4];
			side_s[3] <= sd3;
		end
		if (en[4]) begin
			qm_s      <= 57'(x_s) * 57'(M25);
			side_s[4] <= side_s[3];
		end
		if (en[5])
			side_s[5] <= sd5;
	end

	// line up with the log2 units
	for (genvar k = 6; k < LOG_STAGES; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en[k]) side_s[k] <= side_s[k-1];
		end
	end

	assign side = side_s[LOG_STAGES-1];

endmodule

// File: rtl/f699_select.sv
`timescale 1ns / 1ps
module f699_select (
	input  logic                                 clk,
	input  logic [f699_pkg::SEL_STAGES-1:0]      en,
	input  logic signed [f699_pkg::L2_W-1:0]     lg2d,
	input  logic signed [f699_pkg::L2_W-1:0]     lg2a,
	input  f699_pkg::side_t                      side,
	output logic signed [f699_pkg::GAIN_W-1:0]   gain
);
	import f699_pkg::*;

	// T0
	logic signed [50:0]     pd_s1, pa_s1;
	logic [22:0]            n5_s1;
	logic                   neg_s1;
	logic signed [L2_W-1:0] lga2_s1;
	side_t                  side_s1;
	// T1
	logic signed [L2_W-1:0] lgd_s2, lga_s2, lga2_s2;
	logic [45:0]            q5_s2;
	logic                   neg_s2;
	side_t                  side_s2;
	// T2
	logic signed [GW-1:0]   g1_s3, tl_s3, ts_s3, fs_s3;
	logic                   inr_s3;
	side_t                  side_s3;
	// T3
	logic signed [GW-1:0]   g16_s4;
	// T4
	logic signed [GAIN_W-1:0] gain_s5;

	logic signed [22:0]   t3;
	logic [22:0]          mag3;
	logic signed [22:0]   sdv, thr;
	logic signed [GW-1:0] lgd_e, lga_e, g1_c, tl_c, ts_c, fs_c;
	logic signed [GW-1:0] gmax16, loss_e, g16_c;
	logic                 main_c;
	logic [GW-1:0]        gmag;
	logic [17:0]          gr;
	logic signed [18:0]   gres;
	logic signed [GAIN_W-1:0] gsat;

	always_comb begin
		t3   = (23'(lg2d) <<< 1) + 23'(lg2d);
		mag3 = t3[22] ? 23'(-t3) : 23'(t3);

		sdv = neg_s2 ? -$signed(23'(q5_s2[45:M5_SH])) : $signed(23'(q5_s2[45:M5_SH]));
		thr = 23'(LOG2_1585_Q16) - sdv;

		lgd_e = GW'(lgd_s2);
		lga_e = GW'(lga_s2);
		g1_c  = GW'(2 << QW) + (lgd_e <<< 4) - lgd_e;
		tl_c  = GW'(32 << QW) - ((lga_e <<< 4) + (lga_e <<< 3) + lga_e);
		ts_c  = GW'(52 << QW) - ((lgd_e <<< 3) + (lgd_e <<< 1))
			- ((lga_e <<< 4) + (lga_e <<< 3) + lga_e);
		fs_c  = GW'(10 << QW) - ((lgd_e <<< 3) + (lgd_e <<< 1));

		gmax16 = $signed(GW'(side_s3.gmax) << (QW - FRAC_BITS));
		loss_e = $signed(GW'(side_s3.loss));
		main_c = !side_s3.big && (gmax16 >= g1_s3) && (loss_e < gmax16 - g1_s3);
		if (main_c)
			g16_c = gmax16 - loss_e;
		else if (side_s3.hi_ar)
			g16_c = inr_s3 ? g1_s3 : (side_s3.lt48 ? tl_s3 : -$signed(GW'(10 << QW)));
		else
			g16_c = side_s3.near ? g1_s3 : (side_s3.lt48 ? ts_s3 : fs_s3);

		// round half away from zero to Q.8, then clamp
		gmag = g16_s4[GW-1] ? GW'(-g16_s4) : GW'(g16_s4);
		gr   = 18'((gmag + GW'(1 << (QW - FRAC_BITS - 1))) >> (QW - FRAC_BITS));
		gres = g16_s4[GW-1] ? -$signed(19'(gr)) : $signed(19'(gr));
		if (gres < 19'(GAIN_MIN))
			gsat = GAIN_W'(GAIN_MIN);
		else if (gres > 19'(GAIN_MAX))
			gsat = GAIN_W'(GAIN_MAX);
		else
			gsat = GAIN_W'(gres);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pd_s1   <= lg2d * $signed({1'b0, LOG10_2_Q30});
			pa_s1   <= lg2a * $signed({1'b0, LOG10_2_Q30});
			n5_s1   <= mag3 + 23'd2;
			neg_s1  <= lg2d[L2_W-1];
			lga2_s1 <= lg2a;
			side_s1 <= side;
		end
		if (en[1]) begin
			lgd_s2  <= rnd30(pd_s1);
			lga_s2  <= rnd30(pa_s1);
			q5_s2   <= 46'(n5_s1) * 46'(M5);
			neg_s2  <= neg_s1;
			lga2_s2 <= lga2_s1;
			side_s2 <= side_s1;
		end
		if (en[2]) begin
			g1_s3   <= g1_c;
			tl_s3   <= tl_c;
			ts_s3   <= ts_c;
			fs_s3   <= fs_c;
			inr_s3  <= side_s2.zero || (23'(lga2_s2) < thr);
			side_s3 <= side_s2;
		end
		if (en[3])
			g16_s4 <= g16_c;
		if (en[4])
			gain_s5 <= gsat;
	end

	assign gain = gain_s5;

endmodule

// File: rtl/itu_f699_antenna_gain.sv
`timescale 1ns / 1ps
// Pipeline stages from angle beat to gain beat: 1 fold, 11 log2, 5 select.
// Throughput: one angle per cycle while gain_stall is low; the 10 squaring stages of the log2 units set depth.
// Stalls back up stage by stage; empty stages still fill while the output waits.
// Reset (arst_n low, async): all pipeline valid bits clear, max_gain = 40 dB,
//   aperture_ratio = 100.
module itu_f699_antenna_gain (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_wen,
	input  f699_pkg::reg_idx_t                   cfg_index,
	input  logic [f699_pkg::CFG_W-1:0]           cfg_data,
	// angle channel
	input  logic                                 angle_valid,
	output logic                                 angle_stall,
	input  logic signed [f699_pkg::ANGLE_W-1:0]  off_axis_angle,
	// gain channel
	output logic                                 gain_valid,
	input  logic                                 gain_stall,
	output logic signed [f699_pkg::GAIN_W-1:0]   gain
);
	import f699_pkg::*;

	logic [MAXG_W-1:0]     max_gain_q;
	logic [AR_W-1:0]       aperture_ratio_q;
	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] en;

	logic [ANG_W-1:0]       ang_s1;
	logic [AR_W-1:0]        ar_s1;
	logic [MAXG_W-1:0]      gmax_s1;
	logic signed [L2_W-1:0] lg2d, lg2a;
	side_t                  side;

	// config registers; unknown index writes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gain_q       <= MAX_GAIN_RST;
			aperture_ratio_q <= APERTURE_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_MAX_GAIN: max_gain_q       <= cfg_data[MAXG_W-1:0];
				REG_APERTURE: aperture_ratio_q <= cfg_data[AR_W-1:0];
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its contents move on
	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || !gain_stall;
		for (int k = NUM_STAGES - 2; k >= 0; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= angle_valid;
			for (int k = 1; k < NUM_STAGES; k++)
				if (en[k]) vld_q[k] <= vld_q[k-1];
		end
	end

	assign angle_stall = !en[0];
	assign gain_valid  = vld_q[NUM_STAGES-1];

	f699_front u_front (
		.clk            (clk),
		.en             (en[0]),
		.off_axis_angle (off_axis_angle),
		.ar             (aperture_ratio_q),
		.gmax           (max_gain_q),
		.ang_s1         (ang_s1),
		.ar_s1          (ar_s1),
		.gmax_s1        (gmax_s1)
	);

	// log2 of D/lambda, carried per beat so config timing is exact
	f699_log2 #(.XW(AR_W)) u_log_ar (
		.clk (clk),
		.en  (en[LOG_STAGES:1]),
		.x   (ar_s1),
		.l2  (lg2d)
	);

	f699_log2 #(.XW(ANG_W)) u_log_ang (
		.clk (clk),
		.en  (en[LOG_STAGES:1]),
		.x   (ang_s1),
		.l2  (lg2a)
	);

	// main-lobe loss and branch flags alongside the log units
	f699_loss u_loss (
		.clk  (clk),
		.en   (en[LOG_STAGES:1]),
		.ang  (ang_s1),
		.ar   (ar_s1),
		.gmax (gmax_s1),
		.side (side)
	);

	// log10, g1, segment pick, rounding and clamp
	f699_select u_select (
		.clk  (clk),
		.en   (en[NUM_STAGES-1:LOG_STAGES+1]),
		.lg2d (lg2d),
		.lg2a (lg2a),
		.side (side),
		.gain (gain)
	);

endmodule

// File: rtl/f699_chk.sv
`timescale 1ns / 1ps
`include "itu_f699_antenna_gain_defines.svh"
module f699_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               angle_valid,
	input logic               angle_stall,
	input logic               gain_valid,
	input logic               gain_stall,
	input logic signed [15:0] gain
);

	`F699_ASSERT_NEXT(a_hold, gain_valid && gain_stall, gain_valid && $stable(gain), "gain beat changed while stalled")
	`F699_ASSERT_NOW(a_range, gain_valid, gain >= -16'sd8192, "gain below floor")
	`F699_ASSERT_NOW(a_bp, angle_stall, gain_valid && gain_stall, "angle stalled with output free")

endmodule

bind itu_f699_antenna_gain f699_chk u_chk (.*);
